// ----- hw/rtl/bchd_pkg.sv -----
package bchd_pkg;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_HOLD   = 2'd2,
    EV_DECIDE = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    LVL_RELEASED = 2'd0,
    LVL_PRESSED  = 2'd1,
    LVL_HELD     = 2'd2
  } level_e;

  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD     = 8'd1;

  localparam logic [15:0] DebounceReset = 16'd10;
  localparam logic [15:0] HoldReset     = 16'd500;

  localparam logic [7:0] ClickMax = 8'd255;

  typedef struct packed {
    logic [31:0] time_ms;
    logic        pressed;
  } item_t;

  typedef struct packed {
    event_e      event_res;
    level_e      press_state;
    logic [7:0]  clicks;
  } result_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] hold_ms;
  } cfg_t;

endpackage

// ----- hw/rtl/bchd_core.sv -----
module bchd_core import bchd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic [31:0] prev_time_q, prev_time_d;
  logic [31:0] click_time_q, click_time_d;
  logic [31:0] edge_time_q, edge_time_d;
  logic [31:0] change_time_q, change_time_d;
  logic        raw_q, raw_d;
  level_e      level_q, level_d;
  logic [7:0]  clicks_q, clicks_d;
  event_e      prior_q, ev;

  logic [31:0] now;
  logic [31:0] deb_w, hold_w;
  logic        gap_long, stable, take, timeout, old_bit;

  always_comb begin
    now           = item_i.time_ms;
    deb_w         = {16'd0, cfg_i.debounce_ms};
    hold_w        = {16'd0, cfg_i.hold_ms};
    ev            = EV_NONE;
    raw_d         = item_i.pressed;
    edge_time_d   = (raw_q != item_i.pressed) ? now : edge_time_q;
    change_time_d = change_time_q;
    level_d       = level_q;
    clicks_d      = clicks_q;
    click_time_d  = click_time_q;
    prev_time_d   = now;
    old_bit       = (level_q != LVL_RELEASED);

    gap_long = (now - prev_time_q) > deb_w;
    stable   = (now - edge_time_d) >= deb_w;
    take     = gap_long || stable;

    if (take) begin
      if (item_i.pressed != old_bit) begin
        change_time_d = now;
      end
      if (item_i.pressed) begin
        if (level_q == LVL_RELEASED) begin
          level_d = LVL_PRESSED;
        end else if (level_q == LVL_PRESSED && (now - change_time_q) >= hold_w) begin
          level_d = LVL_HELD;
          ev      = EV_HOLD;
        end
      end else begin
        level_d = LVL_RELEASED;
        if (level_q == LVL_PRESSED) begin
          ev = EV_CLICK;
        end
      end
    end

    timeout = (now - click_time_q) > hold_w;

    if (ev == EV_NONE) begin
      if (timeout && level_d == LVL_RELEASED) begin
        if (prior_q == EV_NONE) begin
          if (clicks_q != 8'd0) begin
            ev       = EV_DECIDE;
            clicks_d = 8'd0;
          end
        end else begin
          // A timeout right after another event clears the count quietly.
          clicks_d = 8'd0;
        end
      end
    end else if (ev == EV_CLICK) begin
      if (clicks_q != ClickMax) begin
        clicks_d = clicks_q + 8'd1;
      end
      click_time_d = now;
    end

    result_o.event_res   = ev;
    result_o.press_state = level_d;
    result_o.clicks      = clicks_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q   <= '0;
      click_time_q  <= '0;
      edge_time_q   <= '0;
      change_time_q <= '0;
      raw_q         <= 1'b0;
      level_q       <= LVL_RELEASED;
      clicks_q      <= '0;
      prior_q       <= EV_NONE;
    end else if (step_i) begin
      prev_time_q   <= prev_time_d;
      click_time_q  <= click_time_d;
      edge_time_q   <= edge_time_d;
      change_time_q <= change_time_d;
      raw_q         <= raw_d;
      level_q       <= level_d;
      clicks_q      <= clicks_d;
      prior_q       <= ev;
    end
  end

endmodule

// ----- hw/rtl/button_click_hold_detector_top.sv -----
// Button click and hold detector.
//
// Requests arrive on the input channel (in_valid_i, in_stall_o, in_item_i), one per
// timestamped raw button sample. Each request yields exactly one result request on
// the output channel (out_valid_o, out_stall_i, out_result_o) holding the event, the
// debounced press level and the running click count.
// A request is taken into an input register, evaluated by a single pass of
// subtract-compare logic once the output register is free or draining, and written
// to the output register, which drives out_valid_o. Throughput is one request per
// cycle while the output is not stalled; the input register and the output
// register form a two-deep pipeline, so a new sample is taken while a finished
// result still waits to be picked up.
// When the receiver stalls, the result holds in the output register; once the input
// register also fills, in_stall_o rises until the output drains.
// Configuration writes (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i) are always
// ready: index 0 sets the debounce time, index 1 the hold time, both in milliseconds
// and taken from the low 16 bits; other indexes are ignored.
// Reset clears all history to released with no clicks, restores debounce 10 ms and
// hold 500 ms, and empties both pipeline registers.
module button_click_hold_detector_top import bchd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  item_t              in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output result_t            out_result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  cfg_t    cfg_q;
  item_t   item_q;
  logic    in_full_q;
  logic    out_full_q;
  result_t result_q;
  result_t result_d;
  logic    advance;
  logic    in_take;

  // The evaluation step fires when a sample is waiting and the output slot is free
  // or is being emptied in this cycle.
  assign advance     = in_full_q && (!out_full_q || !out_stall_i);
  assign in_stall_o  = in_full_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= DebounceReset;
      cfg_q.hold_ms     <= HoldReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE: cfg_q.debounce_ms <= cfg_data_i[15:0];
        CFG_HOLD:     cfg_q.hold_ms     <= cfg_data_i[15:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q  <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_full_q <= 1'b1;
      end else if (advance) begin
        in_full_q <= 1'b0;
      end
      if (advance) begin
        out_full_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_item_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  bchd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .result_o (result_d)
  );

  assign out_valid_o  = out_full_q;
  assign out_result_o = result_q;

  // A hold event always comes with the held level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_full_q && result_q.event_res == EV_HOLD |-> result_q.press_state == LVL_HELD)
    else $error("hold event without held level");

  // A click is reported on release and has been counted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_full_q && result_q.event_res == EV_CLICK
      |-> result_q.press_state == LVL_RELEASED && result_q.clicks != 8'd0)
    else $error("click event with bad level or count");

  // A decided sequence leaves the count cleared with the button up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_full_q && result_q.event_res == EV_DECIDE
      |-> result_q.press_state == LVL_RELEASED && result_q.clicks == 8'd0)
    else $error("decide event with bad level or count");

  // The evaluation step only fires on a waiting sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> in_full_q && !(out_full_q && out_stall_i))
    else $error("evaluation without a free output slot");

endmodule
